### hdl/rfpc_pkg.sv
package rfpc_pkg;

  // Field widths of the stream and configuration ports
  localparam int RAW_W      = 32;
  localparam int COLOR_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register widths
  localparam int FMT_W    = 3;
  localparam int SCR_W_W  = 10;
  localparam int SCR_H_W  = 9;
  localparam int DEST_W   = 10;
  localparam int PITCH_W  = 11;
  localparam int FILL_W   = 24;

  // Defaults for the top-level parameters
  localparam int MAX_COLUMNS_DEF = 512;
  localparam int MAX_ROWS_DEF    = 256;
  localparam int ADDR_BITS_DEF   = 20;

  // Register reset values
  localparam logic [SCR_W_W-1:0] RST_SCR_W = SCR_W_W'(400);
  localparam logic [SCR_H_W-1:0] RST_SCR_H = SCR_H_W'(240);
  localparam logic [PITCH_W-1:0] RST_PITCH = PITCH_W'(400);

  // Source pixel formats
  localparam logic [FMT_W-1:0] FMT_RGBA8  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_RGB8   = 3'd1;
  localparam logic [FMT_W-1:0] FMT_RGB565 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_RGB5A1 = 3'd3;
  localparam logic [FMT_W-1:0] FMT_RGBA4  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_X        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_ENABLE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR    = 3'd7;

  // Decoder controls taken from the configuration registers
  typedef struct packed {
    logic [FMT_W-1:0]  fmt;
    logic              fill_en;
    logic [FILL_W-1:0] fill_color;
  } dec_ctrl_t;

endpackage

### hdl/rfpc_decode.sv
module rfpc_decode
  import rfpc_pkg::*;
(
  input  dec_ctrl_t          ctrl,
  input  logic [RAW_W-1:0]   raw,
  output logic [COLOR_W-1:0] color,
  output logic               ok
);

  function automatic logic [7:0] rep5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] rep6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic logic [7:0] rep4(input logic [3:0] v);
    return {v, v};
  endfunction

  function automatic logic [7:0] rep1(input logic v);
    return {8{v}};
  endfunction

  logic [7:0]  b0, b1, b2, b3;
  logic [15:0] h;

  assign b0 = raw[7:0];
  assign b1 = raw[15:8];
  assign b2 = raw[23:16];
  assign b3 = raw[31:24];
  assign h  = raw[15:0];

  // Fill wins over decode; unknown formats give no item
  always_comb begin
    color = '0;
    ok    = 1'b1;
    if (ctrl.fill_en) begin
      color = {8'hFF, ctrl.fill_color};
    end else begin
      unique case (ctrl.fmt)
        FMT_RGBA8:  color = {b0, b1, b2, b3};
        FMT_RGB8:   color = {8'hFF, b0, b1, b2};
        FMT_RGB565: color = {8'hFF, rep5(h[4:0]), rep6(h[10:5]), rep5(h[15:11])};
        FMT_RGB5A1: color = {rep1(h[0]), rep5(h[5:1]), rep5(h[10:6]), rep5(h[15:11])};
        FMT_RGBA4:  color = {rep4(h[3:0]), rep4(h[7:4]), rep4(h[11:8]), rep4(h[15:12])};
        default:    ok    = 1'b0;
      endcase
    end
  end

endmodule

### hdl/rotating_framebuffer_pixel_converter_top.sv
// Converts a column-major framebuffer stream (each column stored bottom row
// first) into 32-bit pixels with their output buffer word addresses. Supported
// source formats are RGBA8, RGB8, RGB565, RGB5A1 and RGBA4; fields are widened
// to 8 bits by bit replication, and fill mode replaces every pixel by the fill
// color with alpha 255. The block takes one item per clock when the output is
// not stalled, through an input stage that tracks column and row counters and
// an output register holding the decoded pixel and the address
// (dest_y + row) * row_pitch + dest_x + column, computed with one multiplier.
// A pixel in an unsupported format (fill off) is consumed but gives no item.
// frame_start (in_tuser) restarts the counters; out_tlast flags the last pixel
// of a frame. Write configuration only while the pipeline is empty.
module rotating_framebuffer_pixel_converter_top
  import rfpc_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [RAW_W-1:0]      in_tdata,   // [31:0] raw_pixel
  input  logic                  in_tuser,   // [0] frame_start
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [((COLOR_W+ADDR_BITS+7)/8)*8-1:0] out_tdata,
                                            // [31:0] pixel_color,
                                            // [31+ADDR_BITS:32] word_address
  output logic                  out_tlast,  // frame_last
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int OW    = ((RW > DEST_W) ? RW : DEST_W) + 1;
  localparam int SUMW  = ((OW + PITCH_W > ADDR_BITS) ? OW + PITCH_W : ADDR_BITS) + 1;
  localparam int OUT_W = ((COLOR_W + ADDR_BITS + 7) / 8) * 8;

  // Configuration registers
  logic [FMT_W-1:0]   fmt_r;
  logic [SCR_W_W-1:0] scr_w_r;
  logic [SCR_H_W-1:0] scr_h_r;
  logic [DEST_W-1:0]  dest_x_r;
  logic [DEST_W-1:0]  dest_y_r;
  logic [PITCH_W-1:0] pitch_r;
  logic               fill_en_r;
  logic [FILL_W-1:0]  fill_color_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r        <= FMT_RGBA8;
      scr_w_r      <= RST_SCR_W;
      scr_h_r      <= RST_SCR_H;
      dest_x_r     <= '0;
      dest_y_r     <= '0;
      pitch_r      <= RST_PITCH;
      fill_en_r    <= 1'b0;
      fill_color_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PIXEL_FORMAT:  fmt_r        <= cfg_data[FMT_W-1:0];
        CFG_SCREEN_WIDTH:  scr_w_r      <= cfg_data[SCR_W_W-1:0];
        CFG_SCREEN_HEIGHT: scr_h_r      <= cfg_data[SCR_H_W-1:0];
        CFG_DEST_X:        dest_x_r     <= cfg_data[DEST_W-1:0];
        CFG_DEST_Y:        dest_y_r     <= cfg_data[DEST_W-1:0];
        CFG_ROW_PITCH:     pitch_r      <= cfg_data[PITCH_W-1:0];
        CFG_FILL_ENABLE:   fill_en_r    <= cfg_data[0];
        CFG_FILL_COLOR:    fill_color_r <= cfg_data[FILL_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the image size to 1..MAX
  logic [CW:0] w_lim;
  logic [RW:0] h_lim;

  always_comb begin
    if (scr_w_r == '0)                    w_lim = (CW+1)'(1);
    else if (int'(scr_w_r) > MAX_COLUMNS) w_lim = (CW+1)'(MAX_COLUMNS);
    else                                  w_lim = (CW+1)'(scr_w_r);
    if (scr_h_r == '0)                    h_lim = (RW+1)'(1);
    else if (int'(scr_h_r) > MAX_ROWS)    h_lim = (RW+1)'(MAX_ROWS);
    else                                  h_lim = (RW+1)'(scr_h_r);
  end

  // Pipeline handshake
  logic s1_v_r, s1_v_nxt;
  logic out_v_r, out_v_nxt;
  logic s2_free;
  logic in_acc;
  logic dec_ok;

  assign s2_free   = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s2_free;
  assign in_acc    = in_tvalid && in_tready;

  // Column and row counters
  logic [CW-1:0] col_r, col_nxt, col_cur;
  logic [RW-1:0] within_r, within_nxt, within_cur;
  logic [RW:0]   within_inc;
  logic [CW:0]   col_inc;
  logic [RW-1:0] row;
  logic [OW-1:0] row_off;
  logic          last;

  always_comb begin
    col_cur    = (in_tuser || {1'b0, col_r} >= w_lim) ? '0 : col_r;
    within_cur = (in_tuser || {1'b0, within_r} >= h_lim) ? '0 : within_r;
    row        = RW'(h_lim - (RW+1)'(1) - {1'b0, within_cur});
    row_off    = OW'(dest_y_r) + OW'(row);
    last       = ({1'b0, within_cur} == h_lim - (RW+1)'(1)) &&
                 ({1'b0, col_cur} == w_lim - (CW+1)'(1));
    within_inc = {1'b0, within_cur} + (RW+1)'(1);
    col_inc    = {1'b0, col_cur} + (CW+1)'(1);
    col_nxt    = col_r;
    within_nxt = within_r;
    if (in_acc) begin
      if (within_inc >= h_lim) begin
        within_nxt = '0;
        col_nxt    = (col_inc >= w_lim) ? '0 : col_inc[CW-1:0];
      end else begin
        within_nxt = within_inc[RW-1:0];
        col_nxt    = col_cur;
      end
    end
  end

  // Valid bits: fill the input stage, drop unsupported pixels at the output
  always_comb begin
    s1_v_nxt  = s1_v_r;
    out_v_nxt = out_v_r;
    if (in_tready) s1_v_nxt  = in_tvalid;
    if (s2_free)   out_v_nxt = s1_v_r && dec_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      within_r <= '0;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      within_r <= within_nxt;
      s1_v_r   <= s1_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // Input stage payload
  logic [RAW_W-1:0] s1_raw_r;
  logic [CW-1:0]    s1_col_r;
  logic [OW-1:0]    s1_row_off_r;
  logic             s1_last_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_raw_r     <= in_tdata;
      s1_col_r     <= col_cur;
      s1_row_off_r <= row_off;
      s1_last_r    <= last;
    end
  end

  // Decode and address
  dec_ctrl_t          dec_ctrl;
  logic [COLOR_W-1:0] dec_color;
  logic [SUMW-1:0]    addr_full;

  assign dec_ctrl = '{fmt: fmt_r, fill_en: fill_en_r, fill_color: fill_color_r};

  rfpc_decode u_decode (
    .ctrl  (dec_ctrl),
    .raw   (s1_raw_r),
    .color (dec_color),
    .ok    (dec_ok)
  );

  assign addr_full = SUMW'(s1_row_off_r) * SUMW'(pitch_r) + SUMW'(dest_x_r) + SUMW'(s1_col_r);

  // Output register
  logic [COLOR_W-1:0]   out_color_r;
  logic [ADDR_BITS-1:0] out_addr_r;
  logic                 out_last_r;

  always_ff @(posedge clk) begin
    if (s2_free && s1_v_r) begin
      out_color_r <= dec_color;
      out_addr_r  <= addr_full[ADDR_BITS-1:0];
      out_last_r  <= s1_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_W'({out_addr_r, out_color_r});
  assign out_tlast  = out_last_r;

endmodule
